[hdl/pbpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette bitmap pixel expander package
// Shared widths, codes, defaults and record types of the expander.
// ----------------------------------------------------------------------------
package pbpe_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_W      = 8;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int COORD_W     = 12;
    localparam int PIXCNT_W    = 4;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_DIMENSION_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_BPP_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_KEY = 2'd3;

    localparam logic [1:0] BPP_1 = 2'd0;
    localparam logic [1:0] BPP_2 = 2'd1;
    localparam logic [1:0] BPP_4 = 2'd2;
    localparam logic [1:0] BPP_8 = 2'd3;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_RASTER  = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [1:0]       bpp_code;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             alpha_key;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
        logic               alpha_zero;
        logic               out_of_range;
    } pix_side_t;

endpackage

[hdl/pbpe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered and holds while
// no read is enabled. A read of the address being written returns old data.
// ----------------------------------------------------------------------------
module pbpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pbpe_unpack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster unpacker
// Tracks row and column position, writes palette entries and splits each
// raster byte into pixel indices, issuing one palette read per ready cycle.
// ----------------------------------------------------------------------------
module pbpe_unpack #(
    parameter int PALETTE_DEPTH = pbpe_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_DIMENSION = pbpe_pkg::MAX_DIMENSION_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pbpe_pkg::cfg_t                   cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [pbpe_pkg::SLOT_W-1:0]      s_palette_slot,
    input  logic [pbpe_pkg::COLOR_W-1:0]     s_palette_color,
    input  logic [pbpe_pkg::CHAN_W-1:0]      s_raster_byte,
    input  logic                             rd_ready,
    output logic                             ram_we,
    output logic [$clog2(PALETTE_DEPTH)-1:0] ram_waddr,
    output logic [pbpe_pkg::COLOR_W-1:0]     ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(PALETTE_DEPTH)-1:0] ram_raddr,
    output pbpe_pkg::pix_side_t              side
);

    localparam int CFG_MAX = (1 << pbpe_pkg::CFG_W) - 1;
    localparam int DIM_MAX = (MAX_DIMENSION < CFG_MAX) ? MAX_DIMENSION : CFG_MAX;
    localparam int DIM_W   = $clog2(DIM_MAX + 1);
    localparam int BYTE_W  = DIM_W + 1;
    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int SLOT_W  = pbpe_pkg::SLOT_W;
    localparam int COORD_W = pbpe_pkg::COORD_W;
    localparam int PCNT_W  = pbpe_pkg::PIXCNT_W;

    logic [DIM_W-1:0]   col_reg, col_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [DIM_W-1:0]   row_reg, row_next;

    logic               p_valid_reg, p_valid_next;
    logic [7:0]         p_byte_reg, p_byte_next;
    logic [PCNT_W-1:0]  p_cnt_reg, p_cnt_next;
    logic [COORD_W-1:0] p_col_reg, p_col_next;
    logic [COORD_W-1:0] p_row_reg, p_row_next;

    logic [DIM_W-1:0]   width_c, height_c, avail;
    logic [BYTE_W-1:0]  width_x, data_bytes, stride_sum, stride, byte_inc;
    logic [PCNT_W-1:0]  ppb, npix, nsel;
    logic [7:0]         idx, byte_shifted;
    logic               issue, p_done, acc, is_raster, active, load;

    always_comb begin
        if (cfg.width == '0) begin
            width_c = DIM_W'(1);
        end else if (cfg.width > pbpe_pkg::CFG_W'(DIM_MAX)) begin
            width_c = DIM_W'(DIM_MAX);
        end else begin
            width_c = DIM_W'(cfg.width);
        end
        if (cfg.height == '0) begin
            height_c = DIM_W'(1);
        end else if (cfg.height > pbpe_pkg::CFG_W'(DIM_MAX)) begin
            height_c = DIM_W'(DIM_MAX);
        end else begin
            height_c = DIM_W'(cfg.height);
        end
    end

    assign width_x = BYTE_W'(width_c);

    always_comb begin
        unique case (cfg.bpp_code)
            pbpe_pkg::BPP_1: begin
                ppb        = PCNT_W'(8);
                data_bytes = (width_x + BYTE_W'(7)) >> 3;
            end
            pbpe_pkg::BPP_2: begin
                ppb        = PCNT_W'(4);
                data_bytes = (width_x + BYTE_W'(3)) >> 2;
            end
            pbpe_pkg::BPP_4: begin
                ppb        = PCNT_W'(2);
                data_bytes = (width_x + BYTE_W'(1)) >> 1;
            end
            default: begin
                ppb        = PCNT_W'(1);
                data_bytes = width_x;
            end
        endcase
    end

    assign stride_sum = data_bytes + BYTE_W'(3);
    assign stride     = {stride_sum[BYTE_W-1:2], 2'b00};

    always_comb begin
        unique case (cfg.bpp_code)
            pbpe_pkg::BPP_1: begin
                idx          = {7'b0, p_byte_reg[7]};
                byte_shifted = {p_byte_reg[6:0], 1'b0};
            end
            pbpe_pkg::BPP_2: begin
                idx          = {6'b0, p_byte_reg[7:6]};
                byte_shifted = {p_byte_reg[5:0], 2'b00};
            end
            pbpe_pkg::BPP_4: begin
                idx          = {4'b0, p_byte_reg[7:4]};
                byte_shifted = {p_byte_reg[3:0], 4'b0000};
            end
            default: begin
                idx          = p_byte_reg;
                byte_shifted = p_byte_reg;
            end
        endcase
    end

    assign issue     = p_valid_reg && rd_ready;
    assign p_done    = issue && (p_cnt_reg == PCNT_W'(1));
    assign s_ready   = !p_valid_reg || p_done;
    assign acc       = s_valid && s_ready;
    assign is_raster = (s_opcode == pbpe_pkg::OP_RASTER);
    assign active    = (row_reg < height_c);

    assign avail = width_c - col_reg;
    assign nsel  = (avail < DIM_W'(ppb)) ? PCNT_W'(avail) : ppb;
    assign npix  = ((byte_reg < data_bytes) && (col_reg < width_c)) ? nsel : '0;
    assign load  = acc && is_raster && active && (npix != '0);

    assign byte_inc = byte_reg + BYTE_W'(1);

    always_comb begin
        col_next  = col_reg;
        byte_next = byte_reg;
        row_next  = row_reg;
        if (acc && is_raster && active) begin
            if (byte_inc >= stride) begin
                col_next  = '0;
                byte_next = '0;
                row_next  = row_reg + DIM_W'(1);
            end else begin
                col_next  = col_reg + DIM_W'(npix);
                byte_next = byte_inc;
            end
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        p_byte_next  = p_byte_reg;
        p_cnt_next   = p_cnt_reg;
        p_col_next   = p_col_reg;
        p_row_next   = p_row_reg;
        if (issue) begin
            p_byte_next = byte_shifted;
            p_cnt_next  = p_cnt_reg - PCNT_W'(1);
            p_col_next  = p_col_reg + COORD_W'(1);
            if (p_done) begin
                p_valid_next = 1'b0;
            end
        end
        if (load) begin
            p_valid_next = 1'b1;
            p_byte_next  = s_raster_byte;
            p_cnt_next   = npix;
            p_col_next   = COORD_W'(col_reg);
            p_row_next   = COORD_W'(height_c - DIM_W'(1) - row_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            byte_reg    <= '0;
            row_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            byte_reg    <= byte_next;
            row_reg     <= row_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_byte_reg <= p_byte_next;
        p_cnt_reg  <= p_cnt_next;
        p_col_reg  <= p_col_next;
        p_row_reg  <= p_row_next;
    end

    assign ram_we    = acc && !is_raster
                       && ((SLOT_W + 1)'(s_palette_slot) < (SLOT_W + 1)'(PALETTE_DEPTH));
    assign ram_waddr = s_palette_slot[PAL_AW-1:0];
    assign ram_wdata = s_palette_color;
    assign ram_re    = issue;
    assign ram_raddr = idx[PAL_AW-1:0];

    assign side.col          = p_col_reg;
    assign side.row          = p_row_reg;
    assign side.last         = (p_cnt_reg == PCNT_W'(1));
    assign side.alpha_zero   = cfg.alpha_key && (idx == '0);
    assign side.out_of_range = ((SLOT_W + 1)'(idx) >= (SLOT_W + 1)'(PALETTE_DEPTH));

endmodule

[hdl/pbpe_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette lookup and output stage
// Pairs the palette read data with its pixel record and holds the finished
// pixel in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module pbpe_lookup (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           issue,
    input  pbpe_pkg::pix_side_t            side,
    input  logic [pbpe_pkg::COLOR_W-1:0]   ram_rdata,
    output logic                           rd_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pbpe_pkg::CHAN_W-1:0]    m_color_first,
    output logic [pbpe_pkg::CHAN_W-1:0]    m_color_second,
    output logic [pbpe_pkg::CHAN_W-1:0]    m_color_third,
    output logic [pbpe_pkg::CHAN_W-1:0]    m_alpha_value,
    output logic [pbpe_pkg::COORD_W-1:0]   m_pixel_column,
    output logic [pbpe_pkg::COORD_W-1:0]   m_pixel_row,
    output logic                           m_last_of_run
);

    logic                          b_valid_reg, b_valid_next;
    pbpe_pkg::pix_side_t           b_side_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [pbpe_pkg::COLOR_W-1:0]  color_reg;
    logic [pbpe_pkg::CHAN_W-1:0]   alpha_reg;
    logic [pbpe_pkg::COORD_W-1:0]  col_reg;
    logic [pbpe_pkg::COORD_W-1:0]  row_reg;
    logic                          last_reg;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_ready = !b_valid_reg || out_free;

    assign b_valid_next = rd_ready ? issue : b_valid_reg;
    assign m_valid_next = out_free ? b_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_ready && issue) begin
            b_side_reg <= side;
        end
        if (out_free && b_valid_reg) begin
            color_reg <= b_side_reg.out_of_range ? '0 : ram_rdata;
            alpha_reg <= b_side_reg.alpha_zero ? pbpe_pkg::ALPHA_CLEAR
                                               : pbpe_pkg::ALPHA_OPAQUE;
            col_reg   <= b_side_reg.col;
            row_reg   <= b_side_reg.row;
            last_reg  <= b_side_reg.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_color_first  = color_reg[7:0];
    assign m_color_second = color_reg[15:8];
    assign m_color_third  = color_reg[23:16];
    assign m_alpha_value  = alpha_reg;
    assign m_pixel_column = col_reg;
    assign m_pixel_row    = row_reg;
    assign m_last_of_run  = last_reg;

endmodule

[hdl/palette_bitmap_pixel_expander.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette bitmap pixel expander
// Expands indexed-color raster bytes into RGBA pixels through a palette RAM.
//
// The input channel (s_) carries palette writes and raster bytes in file
// order; the output channel (m_) delivers one pixel per item with its column,
// its bottom-up row and a flag on the last pixel of each raster byte.
// The user must write configuration through cfg_wr_en / cfg_index / cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Throughput is one pixel per cycle while the receiver keeps up, set by the
// single read port of the palette RAM. A raster byte yields as many pixels as
// it holds within the row (up to 8 at 1 bit per pixel), and the next item is
// accepted as its last pixel is read; palette writes, pad bytes and bytes past
// the image yield no pixels.
// Reset clears the row, column and byte counters and restores the default
// configuration; palette contents are kept undefined until written.
// When the receiver stalls, the output register holds and the lookup stage
// fills; the unpacker stops issuing reads, and s_ready drops once it is full.
// ----------------------------------------------------------------------------
module palette_bitmap_pixel_expander #(
    parameter int PALETTE_DEPTH = pbpe_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_DIMENSION = pbpe_pkg::MAX_DIMENSION_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pbpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbpe_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [pbpe_pkg::SLOT_W-1:0]       s_palette_slot,
    input  logic [pbpe_pkg::COLOR_W-1:0]      s_palette_color,
    input  logic [pbpe_pkg::CHAN_W-1:0]       s_raster_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pbpe_pkg::CHAN_W-1:0]       m_color_first,
    output logic [pbpe_pkg::CHAN_W-1:0]       m_color_second,
    output logic [pbpe_pkg::CHAN_W-1:0]       m_color_third,
    output logic [pbpe_pkg::CHAN_W-1:0]       m_alpha_value,
    output logic [pbpe_pkg::COORD_W-1:0]      m_pixel_column,
    output logic [pbpe_pkg::COORD_W-1:0]      m_pixel_row,
    output logic                              m_last_of_run
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    pbpe_pkg::cfg_t                cfg_reg, cfg_next;
    pbpe_pkg::pix_side_t           side;
    logic                          rd_ready;
    logic                          ram_we, ram_re;
    logic [PAL_AW-1:0]             ram_waddr, ram_raddr;
    logic [pbpe_pkg::COLOR_W-1:0]  ram_wdata, ram_rdata;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                pbpe_pkg::CFG_BPP_CODE:  cfg_next.bpp_code  = cfg_wdata[1:0];
                pbpe_pkg::CFG_WIDTH:     cfg_next.width     = cfg_wdata;
                pbpe_pkg::CFG_HEIGHT:    cfg_next.height    = cfg_wdata;
                pbpe_pkg::CFG_ALPHA_KEY: cfg_next.alpha_key = cfg_wdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bpp_code  <= pbpe_pkg::BPP_8;
            cfg_reg.width     <= pbpe_pkg::CFG_W'(1);
            cfg_reg.height    <= pbpe_pkg::CFG_W'(1);
            cfg_reg.alpha_key <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pbpe_unpack #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_unpack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_palette_slot  (s_palette_slot),
        .s_palette_color (s_palette_color),
        .s_raster_byte   (s_raster_byte),
        .rd_ready        (rd_ready),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .side            (side)
    );

    pbpe_ram #(
        .WIDTH (pbpe_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pbpe_lookup u_lookup (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .issue          (ram_re),
        .side           (side),
        .ram_rdata      (ram_rdata),
        .rd_ready       (rd_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_color_first  (m_color_first),
        .m_color_second (m_color_second),
        .m_color_third  (m_color_third),
        .m_alpha_value  (m_alpha_value),
        .m_pixel_column (m_pixel_column),
        .m_pixel_row    (m_pixel_row),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
